// ----- hw/rtl/qalu_pkg.sv -----
// Shared types and default sizes for the quaternion arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package qalu_pkg;

	localparam int COMP_WIDTH = 16;
	localparam int FRAC_BITS  = 14;

	typedef enum logic [2:0] {
		FN_ADD   = 3'd0,
		FN_SUB   = 3'd1,
		FN_MUL   = 3'd2,
		FN_CONJ  = 3'd3,
		FN_SCALE = 3'd4,
		FN_NORM  = 3'd5
	} func_t;

	// decoded operation, travels down the pipe with its word
	typedef struct packed {
		logic is_lin;
		logic is_mul;
		logic is_scale;
		logic is_norm;
	} op_sel_t;

endpackage

`default_nettype wire

// ----- hw/rtl/qalu_cmd_if.sv -----
// Command channel: opcode, quaternions p and q, and a scalar.
`timescale 1ns / 1ps
`default_nettype none

interface qalu_cmd_if #(
	parameter int W = qalu_pkg::COMP_WIDTH
);
	logic                valid;
	logic                ready;
	logic [2:0]          func;
	logic signed [W-1:0] p_w;
	logic signed [W-1:0] p_x;
	logic signed [W-1:0] p_y;
	logic signed [W-1:0] p_z;
	logic signed [W-1:0] q_w;
	logic signed [W-1:0] q_x;
	logic signed [W-1:0] q_y;
	logic signed [W-1:0] q_z;
	logic signed [W-1:0] scale;

	modport source (
		output valid, func, p_w, p_x, p_y, p_z, q_w, q_x, q_y, q_z, scale,
		input  ready
	);
	modport sink (
		input  valid, func, p_w, p_x, p_y, p_z, q_w, q_x, q_y, q_z, scale,
		output ready
	);
endinterface

`default_nettype wire

// ----- hw/rtl/qalu_rsp_if.sv -----
// Result channel: quaternion result, norm and saturation flag.
`timescale 1ns / 1ps
`default_nettype none

interface qalu_rsp_if #(
	parameter int W = qalu_pkg::COMP_WIDTH
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] r_w;
	logic signed [W-1:0] r_x;
	logic signed [W-1:0] r_y;
	logic signed [W-1:0] r_z;
	logic [W-1:0]        norm;
	logic                saturated;

	modport source (
		output valid, r_w, r_x, r_y, r_z, norm, saturated,
		input  ready
	);
	modport sink (
		input  valid, r_w, r_x, r_y, r_z, norm, saturated,
		output ready
	);
endinterface

`default_nettype wire

// ----- hw/rtl/quaternion_alu_core.sv -----
// Top level of the fixed-point quaternion arithmetic unit.
// Path from command word to result word: stage 1, stage 2, the square-root stages, the output register.
// Throughput: one word per cycle while the skid slot is empty; the depth is set by the square root, one bit a stage.
// A one-word skid stage behind the output register catches the word leaving the pipe on a stall, then the pipe halts.
// Reset (arst_n low, asynchronous) empties every stage and both output slots.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_alu_core #(
	parameter int COMP_WIDTH = qalu_pkg::COMP_WIDTH,
	parameter int FRAC_BITS  = qalu_pkg::FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	qalu_cmd_if.sink  cmd,
	qalu_rsp_if.source rsp
);

	localparam int W  = COMP_WIDTH;
	localparam int AW = 2 * W + 2;   // accumulator and radicand width
	localparam int TW = 4 * W + 2;   // tag: norm flag, saturation, four components

	// Whole pipe advances unless the skid slot is holding a word.
	logic en;

	// ---------------- stage 1: decode and products ----------------
	logic signed [W-1:0]   p_in [4];
	logic signed [W-1:0]   q_in [4];
	logic                  v_s1;
	qalu_pkg::op_sel_t     sel_s1;
	logic signed [W-1:0]   lin_s1 [4];
	logic                  lin_sat_s1;
	logic signed [2*W-1:0] prod_s1 [4][4];

	assign p_in[0] = cmd.p_w;
	assign p_in[1] = cmd.p_x;
	assign p_in[2] = cmd.p_y;
	assign p_in[3] = cmd.p_z;
	assign q_in[0] = cmd.q_w;
	assign q_in[1] = cmd.q_x;
	assign q_in[2] = cmd.q_y;
	assign q_in[3] = cmd.q_z;

	qalu_prod #(
		.W (W)
	) u_prod (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (cmd.valid),
		.func       (cmd.func),
		.p          (p_in),
		.q          (q_in),
		.scale      (cmd.scale),
		.v_s1       (v_s1),
		.sel_s1     (sel_s1),
		.lin_s1     (lin_s1),
		.lin_sat_s1 (lin_sat_s1),
		.prod_s1    (prod_s1)
	);

	// ---------------- stage 2: Hamilton sums and sum of squares ----------------
	logic signed [AW-1:0] mx [4][4];
	logic signed [AW-1:0] acc_n [4];
	logic [AW-1:0]        nsq_n;

	logic                 v_s2;
	qalu_pkg::op_sel_t    sel_s2;
	logic signed [W-1:0]  lin_s2 [4];
	logic                 lin_sat_s2;
	logic signed [AW-1:0] acc_s2 [4];
	logic [AW-1:0]        nsq_s2;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				mx[i][j] = {{2{prod_s1[i][j][2*W-1]}}, prod_s1[i][j]};
			end
		end
		if (sel_s1.is_mul) begin
			// full-precision sums, one shift afterwards
			acc_n[0] = mx[0][0] - mx[1][1] - mx[2][2] - mx[3][3];
			acc_n[1] = mx[0][1] + mx[1][0] + mx[2][3] - mx[3][2];
			acc_n[2] = mx[0][2] - mx[1][3] + mx[2][0] + mx[3][1];
			acc_n[3] = mx[0][3] + mx[1][2] - mx[2][1] + mx[3][0];
		end else begin
			// scale: the diagonal holds p times the scalar
			for (int k = 0; k < 4; k++) begin
				acc_n[k] = mx[k][k];
			end
		end
		// squares are never negative, so the diagonal adds as unsigned
		nsq_n = AW'(unsigned'(mx[0][0])) + AW'(unsigned'(mx[1][1]))
		      + AW'(unsigned'(mx[2][2])) + AW'(unsigned'(mx[3][3]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s2     <= sel_s1;
			lin_s2     <= lin_s1;
			lin_sat_s2 <= lin_sat_s1;
			acc_s2     <= acc_n;
			nsq_s2     <= nsq_n;
		end
	end

	// ---------------- shift, clip and pick the component result ----------------
	logic signed [AW-1:0] shd [4];
	logic [W+2:0]         hi_bits [4];
	logic [3:0]           ovf3;
	logic signed [W-1:0]  clp [4];
	logic signed [W-1:0]  res3 [4];
	logic                 arith3;
	logic                 sat3;
	logic [AW-1:0]        rad3;
	logic [TW-1:0]        tag3;

	always_comb begin
		arith3 = sel_s2.is_mul | sel_s2.is_scale;
		for (int k = 0; k < 4; k++) begin
			// arithmetic shift: floor towards minus infinity
			shd[k]     = acc_s2[k] >>> FRAC_BITS;
			hi_bits[k] = shd[k][AW-1:W-1];
			ovf3[k]    = !((&hi_bits[k]) | ~(|hi_bits[k]));
			clp[k]     = ovf3[k] ? {shd[k][AW-1], {(W-1){~shd[k][AW-1]}}} : shd[k][W-1:0];
			if (arith3) begin
				res3[k] = clp[k];
			end else if (sel_s2.is_lin) begin
				res3[k] = lin_s2[k];
			end else begin
				res3[k] = '0;
			end
		end
		sat3 = arith3 ? (|ovf3) : (sel_s2.is_lin & lin_sat_s2);
		rad3 = sel_s2.is_norm ? nsq_s2 : '0;
		tag3 = {sel_s2.is_norm, sat3, res3[3], res3[2], res3[1], res3[0]};
	end

	// ---------------- stages 3 onward: square root ----------------
	logic          sq_v;
	logic [W:0]    sq_root;
	logic [TW-1:0] sq_tag;

	qalu_sqrt #(
		.RW (AW),
		.TW (TW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_rad    (rad3),
		.in_tag    (tag3),
		.out_valid (sq_v),
		.out_root  (sq_root),
		.out_tag   (sq_tag)
	);

	// ---------------- final fields ----------------
	logic signed [W-1:0] fin_r [4];
	logic [W-1:0]        fin_norm;
	logic                fin_sat;
	logic                fin_is_norm;

	always_comb begin
		fin_is_norm = sq_tag[4*W+1];
		for (int k = 0; k < 4; k++) begin
			fin_r[k] = sq_tag[k*W +: W];
		end
		// the root only reaches 2^W when every component is the most negative value
		if (!fin_is_norm) begin
			fin_norm = '0;
		end else if (sq_root[W]) begin
			fin_norm = '1;
		end else begin
			fin_norm = sq_root[W-1:0];
		end
		fin_sat = sq_tag[4*W] | (fin_is_norm & sq_root[W]);
	end

	// ---------------- output register and skid slot ----------------
	logic                rsp_v_q;
	logic signed [W-1:0] rsp_r_q [4];
	logic [W-1:0]        rsp_norm_q;
	logic                rsp_sat_q;
	logic                skid_v_q;
	logic signed [W-1:0] skid_r_q [4];
	logic [W-1:0]        skid_norm_q;
	logic                skid_sat_q;
	logic                out_take;

	assign en       = !skid_v_q;
	assign out_take = !rsp_v_q || rsp.ready;

	// Output slot free: refill from skid first, else from the pipe.
	// Output slot stuck: park the word leaving the pipe in the skid slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_take) begin
			if (skid_v_q) begin
				rsp_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				rsp_v_q <= sq_v;
			end
		end else if (!skid_v_q && sq_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			if (skid_v_q) begin
				rsp_r_q    <= skid_r_q;
				rsp_norm_q <= skid_norm_q;
				rsp_sat_q  <= skid_sat_q;
			end else begin
				rsp_r_q    <= fin_r;
				rsp_norm_q <= fin_norm;
				rsp_sat_q  <= fin_sat;
			end
		end else if (!skid_v_q) begin
			skid_r_q    <= fin_r;
			skid_norm_q <= fin_norm;
			skid_sat_q  <= fin_sat;
		end
	end

	assign cmd.ready     = en;
	assign rsp.valid     = rsp_v_q;
	assign rsp.r_w       = rsp_r_q[0];
	assign rsp.r_x       = rsp_r_q[1];
	assign rsp.r_y       = rsp_r_q[2];
	assign rsp.r_z       = rsp_r_q[3];
	assign rsp.norm      = rsp_norm_q;
	assign rsp.saturated = rsp_sat_q;

	// ---------------- assertions ----------------
	// the skid slot only fills behind a waiting output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> rsp_v_q)
		else $error("skid slot holds a word while the output slot is empty");

	// a word leaving the pipe into a stuck output must be parked, not dropped
	a_skid_catches: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_v_q && !rsp.ready && !skid_v_q && sq_v) |=> skid_v_q)
		else $error("word leaving the pipe was lost on an output stall");

	// a nonzero norm comes only from the norm opcode, which zeroes the quaternion
	a_norm_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.norm != '0) |->
			(rsp.r_w == '0 && rsp.r_x == '0 && rsp.r_y == '0 && rsp.r_z == '0))
		else $error("norm result carries a nonzero quaternion");

endmodule

`default_nettype wire

// ----- hw/rtl/qalu_prod.sv -----
// First stage: opcode decode, add/subtract/conjugate, and the sixteen products.
`timescale 1ns / 1ps
`default_nettype none

module qalu_prod #(
	parameter int W = qalu_pkg::COMP_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [2:0]            func,
	input  logic signed [W-1:0]   p [4],
	input  logic signed [W-1:0]   q [4],
	input  logic signed [W-1:0]   scale,
	output logic                  v_s1,
	output qalu_pkg::op_sel_t     sel_s1,
	output logic signed [W-1:0]   lin_s1 [4],
	output logic                  lin_sat_s1,
	output logic signed [2*W-1:0] prod_s1 [4][4]
);

	qalu_pkg::op_sel_t     sel_n;
	logic signed [W:0]     wide [4];
	logic [3:0]            ovf;
	logic signed [W-1:0]   lin_n [4];
	logic                  lin_sat_n;
	logic signed [W-1:0]   b_op [4];
	logic signed [2*W-1:0] prod_n [4][4];

	always_comb begin
		sel_n = '0;
		for (int k = 0; k < 4; k++) begin
			wide[k] = '0;
		end
		unique case (qalu_pkg::func_t'(func))
			qalu_pkg::FN_ADD: begin
				sel_n.is_lin = 1'b1;
				for (int k = 0; k < 4; k++) begin
					wide[k] = {p[k][W-1], p[k]} + {q[k][W-1], q[k]};
				end
			end
			qalu_pkg::FN_SUB: begin
				sel_n.is_lin = 1'b1;
				for (int k = 0; k < 4; k++) begin
					wide[k] = {p[k][W-1], p[k]} - {q[k][W-1], q[k]};
				end
			end
			qalu_pkg::FN_CONJ: begin
				sel_n.is_lin = 1'b1;
				wide[0] = {p[0][W-1], p[0]};
				for (int k = 1; k < 4; k++) begin
					wide[k] = {(W+1){1'b0}} - {p[k][W-1], p[k]};
				end
			end
			qalu_pkg::FN_MUL:   sel_n.is_mul   = 1'b1;
			qalu_pkg::FN_SCALE: sel_n.is_scale = 1'b1;
			qalu_pkg::FN_NORM:  sel_n.is_norm  = 1'b1;
			default: ;
		endcase

		// clip to the component range
		for (int k = 0; k < 4; k++) begin
			ovf[k]   = wide[k][W] ^ wide[k][W-1];
			lin_n[k] = ovf[k] ? {wide[k][W], {(W-1){~wide[k][W]}}} : wide[k][W-1:0];
		end
		lin_sat_n = |ovf;

		// second operand: q for the product, the scalar, or p itself for squares
		for (int j = 0; j < 4; j++) begin
			b_op[j] = sel_n.is_scale ? scale : (sel_n.is_norm ? p[j] : q[j]);
		end

		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				prod_n[i][j] = p[i] * b_op[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s1     <= sel_n;
			lin_s1     <= lin_n;
			lin_sat_s1 <= lin_sat_n;
			prod_s1    <= prod_n;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/qalu_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, with a side tag.
`timescale 1ns / 1ps
`default_nettype none

module qalu_sqrt #(
	parameter int RW = 2 * qalu_pkg::COMP_WIDTH + 2,
	parameter int TW = 4 * qalu_pkg::COMP_WIDTH + 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [RW-1:0]   in_rad,
	input  logic [TW-1:0]   in_tag,
	output logic            out_valid,
	output logic [RW/2-1:0] out_root,
	output logic [TW-1:0]   out_tag
);

	localparam int QW = RW / 2;
	localparam int NS = QW;
	localparam int EW = QW + 2;

	logic          v_s    [NS];
	logic [RW-1:0] rad_s  [NS];
	logic [EW-1:0] rem_s  [NS];
	logic [QW-1:0] root_s [NS];
	logic [TW-1:0] tag_s  [NS];

	logic [RW-1:0] src_rad  [NS];
	logic [EW-1:0] src_rem  [NS];
	logic [QW-1:0] src_root [NS];
	logic [TW-1:0] src_tag  [NS];
	logic [EW+1:0] shv      [NS];
	logic [EW+1:0] trial    [NS];
	logic [EW+1:0] diff     [NS];
	logic [RW-1:0] rad_n    [NS];
	logic [EW-1:0] rem_n    [NS];
	logic [QW-1:0] root_n   [NS];

	always_comb begin
		for (int k = 0; k < NS; k++) begin
			if (k == 0) begin
				src_rad[k]  = in_rad;
				src_rem[k]  = '0;
				src_root[k] = '0;
				src_tag[k]  = in_tag;
			end else begin
				src_rad[k]  = rad_s[k-1];
				src_rem[k]  = rem_s[k-1];
				src_root[k] = root_s[k-1];
				src_tag[k]  = tag_s[k-1];
			end
			// bring down the next two radicand bits, try root*4+1
			shv[k]   = {src_rem[k], src_rad[k][RW-1 -: 2]};
			trial[k] = {2'b00, src_root[k], 2'b01};
			diff[k]  = shv[k] - trial[k];
			if (shv[k] >= trial[k]) begin
				rem_n[k]  = diff[k][EW-1:0];
				root_n[k] = {src_root[k][QW-2:0], 1'b1};
			end else begin
				rem_n[k]  = shv[k][EW-1:0];
				root_n[k] = {src_root[k][QW-2:0], 1'b0};
			end
			rad_n[k] = src_rad[k] << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NS; k++) begin
				rad_s[k]  <= rad_n[k];
				rem_s[k]  <= rem_n[k];
				root_s[k] <= root_n[k];
				tag_s[k]  <= src_tag[k];
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign out_root  = root_s[NS-1];
	assign out_tag   = tag_s[NS-1];

endmodule

`default_nettype wire
